// File: hw/rtl/splr_pkg.sv
// ----------------------------------------------------------------------------
// splr_pkg
// Shared constants, types and tables for the pose/segment residual unit.
// ----------------------------------------------------------------------------
package splr_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int NSTG = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
    localparam int DW = 40;
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] pose_heading;
        logic signed [31:0] first_end_x;
        logic signed [31:0] first_end_y;
        logic signed [31:0] second_end_x;
        logic signed [31:0] second_end_y;
        logic signed [31:0] meas_x;
        logic signed [31:0] meas_y;
        logic signed [15:0] meas_angle;
        logic               which_end;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] err_x;
        logic signed [31:0] err_y;
        logic signed [15:0] err_angle;
    } out_word_t;

    typedef struct packed {
        logic signed [DW-1:0] rx;
        logic signed [DW-1:0] ry;
        logic [31:0]          ra;
        logic signed [DW-1:0] vx;
        logic signed [DW-1:0] vy;
        logic [31:0]          vz;
        logic                 zero_len;
        logic [15:0]          heading;
        logic signed [31:0]   meas_x;
        logic signed [31:0]   meas_y;
        logic [15:0]          meas_angle;
    } cell_word_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051D;
                5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
                5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
                5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
                5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2E;
                5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2F9; 5'd15: r = 32'h0000517C;
                5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517;
                5'd20: r = 32'h0000028B; 5'd21: r = 32'h00000145;
                5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000028; 5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000002; 5'd29: r = 32'h00000001;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

endpackage

// File: hw/rtl/splr_if.sv
// ----------------------------------------------------------------------------
// splr_if
// Valid/ready channel carrying one word of a given struct type.
// ----------------------------------------------------------------------------
interface splr_in_if;
    import splr_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface splr_out_if;
    import splr_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/se2_point_line_residual_unit.sv
// ----------------------------------------------------------------------------
// se2_point_line_residual_unit
// Pose/segment endpoint and normal-angle residual, CORDIC cell chain.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output is not stalled; a prep
// stage, one CORDIC cell per stage shared by the rotation and vectoring
// paths, a gain multiply stage and an output stage that rounds, subtracts
// and saturates.
// The whole pipe advances when the output register is free or being taken.
// Reset clears all valid flags; data registers are not reset.
module se2_point_line_residual_unit
    import splr_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    splr_in_if.sink     in_ch,
    splr_out_if.source  out_ch
);

    logic en;
    logic out_valid_reg;
    out_word_t out_data_reg;

    assign en = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    // prep stage
    logic       p_valid_reg;
    cell_word_t p_reg;
    cell_word_t p_next;
    always_comb
    begin
        logic signed [DW-1:0] lx, ly, dx, dy;
        logic [31:0] a;
        in_word_t d;
        d = in_ch.data;
        lx = DW'(d.which_end ? d.second_end_x : d.first_end_x) - DW'(d.pose_x);
        ly = DW'(d.which_end ? d.second_end_y : d.first_end_y) - DW'(d.pose_y);
        dx = DW'(d.second_end_x) - DW'(d.first_end_x);
        dy = DW'(d.second_end_y) - DW'(d.first_end_y);
        a = {16'(16'd0 - d.pose_heading), 16'd0};
        if (a[31] != a[30])
        begin
            lx = -lx;
            ly = -ly;
            a = a + 32'h80000000;
        end
        p_next.rx = lx;
        p_next.ry = ly;
        p_next.ra = a;
        p_next.vz = 32'd0;
        // vector (dy, -dx)
        if (dy[DW-1])
        begin
            p_next.vx = -dy;
            p_next.vy = dx;
            p_next.vz = 32'h80000000;
        end
        else
        begin
            p_next.vx = dy;
            p_next.vy = -dx;
        end
        p_next.zero_len = (dx == '0) && (dy == '0);
        p_next.heading = d.pose_heading;
        p_next.meas_x = d.meas_x;
        p_next.meas_y = d.meas_y;
        p_next.meas_angle = d.meas_angle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= in_ch.valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
            p_reg <= p_next;
    end

    logic       cv [0:NSTG];
    cell_word_t cw [0:NSTG];
    assign cv[0] = p_valid_reg;
    assign cw[0] = p_reg;

    for (genvar g = 0; g < NSTG; g++)
    begin : g_cell
        splr_cell u_cell (
            .clk(clk), .rst_n(rst_n), .en(en), .idx(5'(g)),
            .valid_in(cv[g]), .word_in(cw[g]),
            .valid_out(cv[g+1]), .word_out(cw[g+1])
        );
    end

    // gain multiply stage
    cell_word_t c;
    assign c = cw[NSTG];
    logic              m_valid_reg;
    logic [DW+29:0]    mx_reg, my_reg;
    logic              nx_reg, ny_reg;
    logic [15:0]       ang_reg;
    logic signed [31:0] meas_x_reg, meas_y_reg;
    logic [DW-1:0]     ax, ay;
    logic [15:0]       nang;
    assign ax = c.rx[DW-1] ? DW'(-c.rx) : c.rx;
    assign ay = c.ry[DW-1] ? DW'(-c.ry) : c.ry;
    assign nang = c.zero_len ? 16'd0 :
        16'(16'((c.vz + 32'h8000) >> 16) - c.heading);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= cv[NSTG];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= (DW+30)'(ax) * (DW+30)'(GAIN_Q30);
            my_reg <= (DW+30)'(ay) * (DW+30)'(GAIN_Q30);
            nx_reg <= c.rx[DW-1];
            ny_reg <= c.ry[DW-1];
            ang_reg <= 16'(nang - c.meas_angle);
            meas_x_reg <= c.meas_x;
            meas_y_reg <= c.meas_y;
        end
    end

    // round, subtract, saturate
    logic signed [DW:0] gx, gy, ex, ey;
    logic [DW+29:0] rxm, rym;
    always_comb
    begin
        rxm = (mx_reg + (DW+30)'(1 << 29)) >> 30;
        rym = (my_reg + (DW+30)'(1 << 29)) >> 30;
        gx = nx_reg ? -$signed((DW+1)'(rxm)) : $signed((DW+1)'(rxm));
        gy = ny_reg ? -$signed((DW+1)'(rym)) : $signed((DW+1)'(rym));
        ex = gx - (DW+1)'(meas_x_reg);
        ey = gy - (DW+1)'(meas_y_reg);
    end

    function automatic logic [31:0] sat(input logic signed [DW:0] v);
        logic [31:0] r;
        begin
            if (v > (DW+1)'(64'sh7FFFFFFF))
                r = 32'h7FFFFFFF;
            else if (v < -(DW+1)'(64'sh80000000))
                r = 32'h80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= m_valid_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg.err_x <= sat(ex);
            out_data_reg.err_y <= sat(ey);
            out_data_reg.err_angle <= ang_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("output word changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ch.ready)
        else $error("input stalled with empty output");
    a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        en && m_valid_reg |=> out_valid_reg)
        else $error("word lost at output stage");

endmodule

// File: hw/rtl/splr_cell.sv
// ----------------------------------------------------------------------------
// splr_cell
// One CORDIC step for both the rotation and the vectoring datapath.
// ----------------------------------------------------------------------------
module splr_cell
    import splr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [4:0] idx,
    input  logic       valid_in,
    input  cell_word_t word_in,
    output logic       valid_out,
    output cell_word_t word_out
);

    logic       valid_reg;
    cell_word_t word_reg;
    cell_word_t word_next;
    logic [31:0] at;

    always_comb
    begin
        at = atan_lut(idx);
        word_next = word_in;
        if (!word_in.ra[31])
        begin
            word_next.rx = word_in.rx - (word_in.ry >>> idx);
            word_next.ry = word_in.ry + (word_in.rx >>> idx);
            word_next.ra = word_in.ra - at;
        end
        else
        begin
            word_next.rx = word_in.rx + (word_in.ry >>> idx);
            word_next.ry = word_in.ry - (word_in.rx >>> idx);
            word_next.ra = word_in.ra + at;
        end
        if (!word_in.vy[DW-1])
        begin
            word_next.vx = word_in.vx + (word_in.vy >>> idx);
            word_next.vy = word_in.vy - (word_in.vx >>> idx);
            word_next.vz = word_in.vz + at;
        end
        else
        begin
            word_next.vx = word_in.vx - (word_in.vy >>> idx);
            word_next.vy = word_in.vy + (word_in.vx >>> idx);
            word_next.vz = word_in.vz - at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            word_reg <= word_next;
    end

    assign valid_out = valid_reg;
    assign word_out  = word_reg;

endmodule
